[rtl/core/aafd_pkg.sv]
`default_nettype none
package aafd_pkg;

  // Field widths
  localparam int unsigned AMPLITUDE_BITS = 8;
  localparam int unsigned TOTAL_BITS     = 32;
  localparam int unsigned FIRE_BITS      = 8;
  localparam int unsigned TOTAL_OUT_BITS = 32;
  localparam int unsigned SENS_BITS      = 7;
  localparam int unsigned MIN_FIRE_BITS  = 8;
  localparam int unsigned CMP_BITS       =
    (AMPLITUDE_BITS > MIN_FIRE_BITS) ? AMPLITUDE_BITS : MIN_FIRE_BITS;

  // Attack tracking
  localparam int unsigned FALL_LIMIT = 9;
  localparam int unsigned SENS_MAX   = 100;

  // Intensity average, unsigned Q1.16
  localparam int unsigned SMOOTH_BITS    = 17;
  localparam int unsigned SMOOTH_FRAC    = 16;
  localparam int unsigned SMOOTH_MAX     = (1 << SMOOTH_BITS) - 1;
  localparam int unsigned COEF_BITS      = 16;
  localparam int unsigned KEEP_COEF      = 62259;
  localparam int unsigned NEW_COEF       = 3277;
  localparam int unsigned AMP_TO_Q16     = 512;
  localparam int unsigned NEW_SCALE      = AMP_TO_Q16 * NEW_COEF;
  localparam int unsigned NEW_SCALE_BITS = 21;
  localparam int unsigned KEEP_PROD_BITS = SMOOTH_BITS + COEF_BITS;
  localparam int unsigned NEW_PROD_BITS  = AMPLITUDE_BITS + NEW_SCALE_BITS;
  localparam int unsigned ACC_BITS       =
    ((KEEP_PROD_BITS > NEW_PROD_BITS) ? KEEP_PROD_BITS : NEW_PROD_BITS) + 1;
  localparam int unsigned AVG_BITS       = ACC_BITS - SMOOTH_FRAC;

  typedef struct packed {
    logic [AMPLITUDE_BITS-1:0] amplitude;
    logic                      clear_total;
  } aafd_item_t;

endpackage
`default_nettype wire

[rtl/core/aafd_frame_if.sv]
`default_nettype none
interface aafd_frame_if;
  logic                                valid;
  logic                                ready;
  logic [aafd_pkg::AMPLITUDE_BITS-1:0] amplitude;
  logic                                clear_total;

  modport source (output valid, output amplitude, output clear_total, input ready);
  modport sink   (input valid, input amplitude, input clear_total, output ready);
endinterface
`default_nettype wire

[rtl/core/aafd_report_if.sv]
`default_nettype none
interface aafd_report_if;
  logic                                valid;
  logic                                ready;
  logic [aafd_pkg::FIRE_BITS-1:0]      fire;
  logic [aafd_pkg::SMOOTH_BITS-1:0]    intensity;
  logic [aafd_pkg::TOTAL_OUT_BITS-1:0] fire_total;

  modport source (output valid, output fire, output intensity, output fire_total,
                  input ready);
  modport sink   (input valid, input fire, input intensity, input fire_total,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/aafd_attack.sv]
`default_nettype none
module aafd_attack (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  aafd_pkg::aafd_item_t               item,
  input  logic [aafd_pkg::MIN_FIRE_BITS-1:0] min_fire,
  output logic [aafd_pkg::AMPLITUDE_BITS-1:0] fire
);
  localparam int unsigned AW = aafd_pkg::AMPLITUDE_BITS;

  logic [AW-1:0] previous_level;
  logic [AW-1:0] previous_level_next;
  logic [AW-1:0] attack_sum;
  logic [AW-1:0] attack_sum_next;
  logic [AW-1:0] fall_floor;
  logic [AW-1:0] amp;
  logic [AW:0]   rise_sum;

  always_comb begin
    fall_floor = previous_level - AW'(aafd_pkg::FALL_LIMIT);
    amp        = item.amplitude;
    // Limit the fall to one step per frame
    if (previous_level >= AW'(aafd_pkg::FALL_LIMIT) && item.amplitude < fall_floor) begin
      amp = fall_floor;
    end
    rise_sum            = {1'b0, attack_sum} + {1'b0, amp - previous_level};
    attack_sum_next     = attack_sum;
    fire                = '0;
    previous_level_next = amp;
    if (amp > previous_level) begin
      attack_sum_next = rise_sum[AW] ? {AW{1'b1}} : rise_sum[AW-1:0];
    end else if (amp < previous_level) begin
      attack_sum_next = '0;
      // Drop fires at or below the sensitivity floor
      if (aafd_pkg::CMP_BITS'(attack_sum) > aafd_pkg::CMP_BITS'(min_fire)) begin
        fire = attack_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= '0;
      attack_sum     <= '0;
    end else if (advance) begin
      previous_level <= previous_level_next;
      attack_sum     <= attack_sum_next;
    end
  end
endmodule
`default_nettype wire

[rtl/core/aafd_smoother.sv]
`default_nettype none
module aafd_smoother (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  aafd_pkg::aafd_item_t             item,
  output logic [aafd_pkg::SMOOTH_BITS-1:0] smoothed_level_next
);
  localparam int unsigned KW = aafd_pkg::KEEP_PROD_BITS;
  localparam int unsigned NW = aafd_pkg::NEW_PROD_BITS;
  localparam int unsigned CW = aafd_pkg::ACC_BITS;
  localparam int unsigned VW = aafd_pkg::AVG_BITS;

  logic [aafd_pkg::SMOOTH_BITS-1:0] smoothed_level;
  logic [KW-1:0] keep_prod;
  logic [NW-1:0] new_prod;
  logic [CW-1:0] acc;
  logic [VW-1:0] avg;

  always_comb begin
    keep_prod = KW'(smoothed_level) * KW'(aafd_pkg::KEEP_COEF);
    new_prod  = NW'(item.amplitude) * NW'(aafd_pkg::NEW_SCALE);
    acc       = CW'(keep_prod) + CW'(new_prod);
    avg       = acc[CW-1:aafd_pkg::SMOOTH_FRAC];
    if (avg > VW'(aafd_pkg::SMOOTH_MAX)) begin
      smoothed_level_next = aafd_pkg::SMOOTH_BITS'(aafd_pkg::SMOOTH_MAX);
    end else begin
      smoothed_level_next = avg[aafd_pkg::SMOOTH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_level <= '0;
    end else if (advance) begin
      smoothed_level <= smoothed_level_next;
    end
  end
endmodule
`default_nettype wire

[rtl/core/aafd_total.sv]
`default_nettype none
module aafd_total (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  aafd_pkg::aafd_item_t                item,
  input  logic [aafd_pkg::AMPLITUDE_BITS-1:0] fire,
  output logic [aafd_pkg::TOTAL_BITS-1:0]     fire_sum_next
);
  localparam int unsigned TW = aafd_pkg::TOTAL_BITS;

  logic [TW-1:0] fire_sum;
  logic [TW-1:0] base;
  logic [TW:0]   sum;

  always_comb begin
    base = item.clear_total ? '0 : fire_sum;
    sum  = {1'b0, base} + (TW + 1)'(fire);
    // Saturate at full scale
    fire_sum_next = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_sum <= '0;
    end else if (advance) begin
      fire_sum <= fire_sum_next;
    end
  end
endmodule
`default_nettype wire

[rtl/core/audio_attack_fire_detector_core.sv]
// Audio attack fire detector. Each frame transaction carries one amplitude
// and a clear_total flag; each one yields exactly one report transaction with
// the released attack (fire), the smoothed intensity (unsigned Q1.16, level
// divided by 128) and the saturating running total of fires. Amplitude falls
// are limited to 9 per frame; rises accumulate into an attack level that is
// released on the first fall and dropped to zero when it is at or below
// (100 - fire_sensitivity) * 2. fire_sensitivity resets to 100 (keep every
// nonzero fire); values above 100 act as 100. Write it only while the block
// is idle. Throughput is one frame per clock unless the report stalls: the
// frame register feeds one pass of compare/add logic and 17x16 and 8x21
// constant multiplies into the report register.
// The report register decouples the sides; frame.ready drops only while both
// registers are full and the report is stalled.
`default_nettype none
module audio_attack_fire_detector_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [aafd_pkg::SENS_BITS-1:0] cfg_data,
  aafd_frame_if.sink                     frame,
  aafd_report_if.source                  report
);
  localparam int unsigned SW = aafd_pkg::SENS_BITS;
  localparam int unsigned MW = aafd_pkg::MIN_FIRE_BITS;

  // Sensitivity, kept as the derived fire floor
  logic [MW-1:0] min_fire;
  logic [SW-1:0] sens_clamped;
  logic [MW-1:0] min_fire_next;

  // Frame register
  logic                 stage_valid;
  aafd_pkg::aafd_item_t stage_item;
  logic                 advance;

  // Report register
  logic                                report_valid;
  logic [aafd_pkg::FIRE_BITS-1:0]      report_fire;
  logic [aafd_pkg::SMOOTH_BITS-1:0]    report_intensity;
  logic [aafd_pkg::TOTAL_OUT_BITS-1:0] report_total;

  // Datapath results for the item in the frame register
  logic [aafd_pkg::AMPLITUDE_BITS-1:0] fire;
  logic [aafd_pkg::SMOOTH_BITS-1:0]    smoothed_level_next;
  logic [aafd_pkg::TOTAL_BITS-1:0]     fire_sum_next;

  // Clamp sensitivity to 100 and convert to the fire floor
  always_comb begin
    sens_clamped  = (cfg_data > SW'(aafd_pkg::SENS_MAX)) ? SW'(aafd_pkg::SENS_MAX) : cfg_data;
    min_fire_next = MW'((MW'(aafd_pkg::SENS_MAX) - MW'(sens_clamped)) << 1);
  end

  // Move the staged item into the report register when it is free or draining
  assign advance     = stage_valid && (!report_valid || report.ready);
  assign frame.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_fire <= '0;
    end else if (cfg_write) begin
      min_fire <= min_fire_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (frame.valid && frame.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // Capture the payload on every accepted frame transaction
  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      stage_item.amplitude   <= frame.amplitude;
      stage_item.clear_total <= frame.clear_total;
    end
  end

  aafd_attack u_attack (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (stage_item),
    .min_fire (min_fire),
    .fire     (fire)
  );

  aafd_smoother u_smoother (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .item                (stage_item),
    .smoothed_level_next (smoothed_level_next)
  );

  aafd_total u_total (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (stage_item),
    .fire          (fire),
    .fire_sum_next (fire_sum_next)
  );

  // Report valid: set on advance, drop once taken with nothing behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (advance) begin
      report_valid <= 1'b1;
    end else if (report.ready) begin
      report_valid <= 1'b0;
    end
  end

  // Hold the report payload until the next advance
  always_ff @(posedge clk) begin
    if (advance) begin
      report_fire      <= aafd_pkg::FIRE_BITS'(fire);
      report_intensity <= smoothed_level_next;
      report_total     <= aafd_pkg::TOTAL_OUT_BITS'(fire_sum_next);
    end
  end

  assign report.valid      = report_valid;
  assign report.fire       = report_fire;
  assign report.intensity  = report_intensity;
  assign report.fire_total = report_total;
endmodule
`default_nettype wire

[rtl/core/aafd_checker.sv]
`default_nettype none
module aafd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                report_valid,
  input logic                                report_ready,
  input logic [aafd_pkg::FIRE_BITS-1:0]      fire,
  input logic [aafd_pkg::TOTAL_OUT_BITS-1:0] fire_total
);
  // No report may be pending right after reset
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !report_valid)
    else $error("report valid right after reset");

  // A stalled report holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(fire_total) && $stable(fire))
    else $error("stalled report changed");

  // The total already includes this report's fire (or is saturated)
  a_total_covers_fire: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> fire_total >= aafd_pkg::TOTAL_OUT_BITS'(fire))
    else $error("fire total below fire");
endmodule

bind audio_attack_fire_detector_core aafd_checker u_aafd_checker (
  .clk          (clk),
  .rst          (rst),
  .report_valid (report.valid),
  .report_ready (report.ready),
  .fire         (report.fire),
  .fire_total   (report.fire_total)
);
`default_nettype wire

[tb/audio_attack_fire_detector_core_tb.sv]
`timescale 1ns / 1ps

typedef struct packed {
  logic [aafd_pkg::FIRE_BITS-1:0]      fire;
  logic [aafd_pkg::SMOOTH_BITS-1:0]    intensity;
  logic [aafd_pkg::TOTAL_OUT_BITS-1:0] fire_total;
} fire_report_t;

class fire_scoreboard;
  logic [aafd_pkg::SENS_BITS-1:0]      sensitivity;
  logic [aafd_pkg::AMPLITUDE_BITS-1:0] level;
  logic [aafd_pkg::AMPLITUDE_BITS-1:0] attack;
  logic [aafd_pkg::SMOOTH_BITS-1:0]    smooth;
  logic [aafd_pkg::TOTAL_BITS-1:0]     total;
  fire_report_t                        expected_reports[$];
  int                                  errors;

  function new();
    sensitivity = aafd_pkg::SENS_BITS'(aafd_pkg::SENS_MAX);
    level       = '0;
    attack      = '0;
    smooth      = '0;
    total       = '0;
    errors      = 0;
  endfunction

  function void set_sensitivity(logic [aafd_pkg::SENS_BITS-1:0] value);
    sensitivity = value;
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  // Advance the predicted state by one frame and queue the report it yields.
  function void note_frame(logic [aafd_pkg::AMPLITUDE_BITS-1:0] amplitude,
                           logic clear);
    logic [aafd_pkg::AMPLITUDE_BITS-1:0] held;
    logic [aafd_pkg::AMPLITUDE_BITS:0]   rise_sum;
    logic [aafd_pkg::FIRE_BITS-1:0]      fire;
    int unsigned                         sens_eff;
    int unsigned                         min_fire;
    logic [63:0]                         acc;
    logic [aafd_pkg::TOTAL_BITS:0]       sum;
    fire_report_t                        r;
    held     = amplitude;
    fire     = '0;
    sens_eff = (sensitivity > aafd_pkg::SENS_MAX) ? aafd_pkg::SENS_MAX : sensitivity;
    min_fire = (aafd_pkg::SENS_MAX - sens_eff) * 2;
    if (level >= aafd_pkg::FALL_LIMIT && held < level - aafd_pkg::FALL_LIMIT)
      held = level - aafd_pkg::AMPLITUDE_BITS'(aafd_pkg::FALL_LIMIT);
    if (held > level) begin
      rise_sum = attack + (held - level);
      attack   = rise_sum[aafd_pkg::AMPLITUDE_BITS] ? '1 : rise_sum[aafd_pkg::AMPLITUDE_BITS-1:0];
    end
    if (held < level) begin
      fire   = attack;
      attack = '0;
      if (fire <= min_fire)
        fire = '0;
    end
    level = held;
    acc = (64'(smooth) * aafd_pkg::KEEP_COEF + 64'(amplitude) * aafd_pkg::NEW_SCALE)
          >> aafd_pkg::SMOOTH_FRAC;
    smooth = (acc > aafd_pkg::SMOOTH_MAX) ? aafd_pkg::SMOOTH_BITS'(aafd_pkg::SMOOTH_MAX)
                                          : acc[aafd_pkg::SMOOTH_BITS-1:0];
    if (clear)
      total = '0;
    sum   = total + fire;
    total = sum[aafd_pkg::TOTAL_BITS] ? '1 : sum[aafd_pkg::TOTAL_BITS-1:0];
    r.fire       = fire;
    r.intensity  = smooth;
    r.fire_total = total[aafd_pkg::TOTAL_OUT_BITS-1:0];
    expected_reports.push_back(r);
  endfunction

  function void check_report(fire_report_t got);
    fire_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: report with no frame outstanding: fire %0d intensity %0d total %0d",
               $time, got.fire, got.intensity, got.fire_total);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    if (got.fire !== want.fire) begin
      $display("%0t: fire expected %0d actual %0d", $time, want.fire, got.fire);
      errors++;
    end
    if (got.intensity !== want.intensity) begin
      $display("%0t: intensity expected %0d actual %0d", $time, want.intensity, got.intensity);
      errors++;
    end
    if (got.fire_total !== want.fire_total) begin
      $display("%0t: fire_total expected %0d actual %0d", $time, want.fire_total,
               got.fire_total);
      errors++;
    end
  endfunction
endclass

module audio_attack_fire_detector_core_tb;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_ITEMS    = 140;
  localparam int NUM_PHASES     = 8;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [aafd_pkg::SENS_BITS-1:0] cfg_data;

  aafd_frame_if  frame_bus();
  aafd_report_if report_bus();

  fire_scoreboard board = new();

  // Idle percentages for each side, set per phase.
  int src_idle_pct;
  int sink_stall_pct;
  // Receiver hold-off: the main thread raises the request, the receiver counts.
  bit hold_request;
  int hold_left;
  int quiet_cycles;
  int phase_sent;

  audio_attack_fire_detector_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .frame     (frame_bus),
    .report    (report_bus)
  );

  always #1 clk = ~clk;

  // Receiver: decide ready at the falling edge so it is stable at the next
  // rising edge. A requested hold-off keeps ready low for a long stretch.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      report_bus.ready = 1'b0;
      hold_left--;
    end else begin
      report_bus.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Check every report transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && report_bus.valid === 1'b1 && report_bus.ready === 1'b1)
      board.check_report({report_bus.fire, report_bus.intensity, report_bus.fire_total});
  end

  // Watchdog: count cycles without any transaction on either side.
  always @(posedge clk) begin
    if ((frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1) ||
        (report_bus.valid === 1'b1 && report_bus.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d reports outstanding", $time, board.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one frame, idling first at the configured rate. Valid stays high
  // after acceptance so back-to-back frames need no drop; the caller drops it.
  task automatic send_frame(logic [aafd_pkg::AMPLITUDE_BITS-1:0] amplitude, logic clear);
    while ($urandom_range(99) < src_idle_pct) begin
      frame_bus.valid = 1'b0;
      @(negedge clk);
    end
    frame_bus.valid       = 1'b1;
    frame_bus.amplitude   = amplitude;
    frame_bus.clear_total = clear;
    do @(posedge clk); while (frame_bus.ready !== 1'b1);
    board.note_frame(amplitude, clear);
    phase_sent++;
    @(negedge clk);
  endtask

  // Stop offering and hold until every predicted report has come back.
  task automatic drain();
    frame_bus.valid = 1'b0;
    while (board.pending() != 0)
      @(negedge clk);
  endtask

  // Write the sensitivity register only with the block empty; the extra
  // cycles cover the two-stage pipeline.
  task automatic write_sensitivity(logic [aafd_pkg::SENS_BITS-1:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_data  = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    board.set_sensitivity(value);
  endtask

  // Bring the held level down to zero with silent frames.
  task automatic settle_to_floor();
    while (board.level != 0)
      send_frame('0, 1'b0);
  endtask

  function automatic logic rare_clear();
    return ($urandom_range(15) == 0);
  endfunction

  // Mostly well-formed attacks: a quiet stretch, a ramp to a random peak,
  // then a release frame. The rest is raw noise.
  task automatic random_burst();
    int quiet;
    int base;
    int peak;
    int steps;
    int noise;
    if ($urandom_range(99) < 75) begin
      quiet = $urandom_range(30);
      base  = $urandom_range(8);
      repeat (quiet) send_frame(8'($urandom_range(base)), rare_clear());
      peak  = $urandom_range(255);
      steps = $urandom_range(1, 4);
      for (int k = 1; k <= steps; k++)
        send_frame(8'(base + (peak - base) * k / steps), rare_clear());
      send_frame(8'($urandom_range(peak)), rare_clear());
    end else begin
      noise = $urandom_range(1, 8);
      repeat (noise) send_frame(8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [aafd_pkg::SENS_BITS-1:0] sens_plan[NUM_PHASES];
    clk                   = 1'b0;
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_data              = '0;
    frame_bus.valid       = 1'b0;
    frame_bus.amplitude   = '0;
    frame_bus.clear_total = 1'b0;
    report_bus.ready      = 1'b0;
    src_idle_pct          = 0;
    sink_stall_pct        = 0;
    hold_request          = 1'b0;
    hold_left             = 0;
    quiet_cycles          = 0;
    phase_sent            = 0;
    sens_plan = '{7'd127, 7'd101, 7'd0, 7'd100, 7'd1, 7'd99, 7'd50, 7'($urandom)};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, reset sensitivity (every nonzero fire kept).
    send_frame(8'd0, 1'b0);
    send_frame(8'd5, 1'b0);
    send_frame(8'd0, 1'b0);    // small previous level: fall not limited
    send_frame(8'd8, 1'b0);
    send_frame(8'd0, 1'b0);
    send_frame(8'd9, 1'b0);
    send_frame(8'd0, 1'b0);    // level at the limit: falls straight to zero
    send_frame(8'd10, 1'b0);
    send_frame(8'd0, 1'b0);    // fall limited to one
    send_frame(8'd0, 1'b0);    // release of an empty attack
    send_frame(8'd255, 1'b1);  // full-scale rise, total cleared
    send_frame(8'd0, 1'b0);    // full attack released, fall limited
    send_frame(8'd255, 1'b0);
    send_frame(8'd255, 1'b0);
    send_frame(8'd240, 1'b1);  // clear and add in the same frame

    // Directed, zero sensitivity: fires of 200 and below are dropped.
    write_sensitivity(7'd0);
    settle_to_floor();
    send_frame(8'd200, 1'b0);
    send_frame(8'd0, 1'b0);
    settle_to_floor();
    send_frame(8'd201, 1'b0);
    send_frame(8'd0, 1'b0);

    // Random phases, each with its own sensitivity and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_sensitivity(sens_plan[p]);
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 77;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 77;
        end
        default: begin
          src_idle_pct   = 13;
          sink_stall_pct = 13;
        end
      endcase
      // Back up the pipeline: receiver holds off while frames keep coming.
      if (p == 0)
        hold_request = 1'b1;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        random_burst();
        // In phase 1, mid-phase, pause the sender after each burst until every report is home.
        if (p == 1 && phase_sent >= PHASE_ITEMS / 2 && phase_sent < PHASE_ITEMS / 2 + 40)
          drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
